// ===== hdl/adpcm_frame_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// adpcm frame decoder assertion macros
// wrappers for concurrent checks, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef ADPCM_FRAME_DECODER_MACROS_SVH
`define ADPCM_FRAME_DECODER_MACROS_SVH
`ifndef ASSERT_OFF
// check that is ignored while reset is asserted
`define ADF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("adf check failed");
// check that must also hold during reset
`define ADF_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("adf check failed");
`else
`define ADF_ASSERT(label, clk, rst_n, prop)
`define ADF_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== hdl/adf_pkg.sv =====
// ----------------------------------------------------------------------------
// adf_pkg
// shared types and constants of the adpcm frame decoder
// ----------------------------------------------------------------------------
package adf_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned NumCoefRegs = 4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegCoefPairs01  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCoefPairs23  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCoefPairs45  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCoefPairs67  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegInitHistory  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSampleCount  = 3'd5;

  localparam logic [3:0]  HeaderPos   = 4'd0;
  localparam logic [3:0]  PosStep     = 4'd2;
  localparam logic [4:0]  FracBits    = 5'd11;
  localparam logic [10:0] HalfLsb     = 11'd1024;
  localparam logic signed [23:0] SatMax = 24'sd32767;
  localparam logic signed [23:0] SatMin = -24'sd32768;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first;
  } adf_in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
    logic               block_done;
  } adf_out_t;

  // one sample job handed from front to back
  typedef struct packed {
    logic        reload;
    logic [31:0] hist;
    logic [3:0]  nibble;
    logic [2:0]  pred;
    logic [3:0]  shift;
    logic        last;
    logic        done;
  } adf_op_t;

  typedef struct packed {
    logic    push0;
    logic    push1;
    adf_op_t op0;
    adf_op_t op1;
  } adf_push_t;

  typedef struct packed {
    logic [NumCoefRegs-1:0][CfgDataW-1:0] coef;
    logic [31:0]                          init_hist;
  } adf_cfg_t;

endpackage

// ===== hdl/adpcm_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// adpcm_frame_decoder
// 4-bit adpcm decoder for one channel, 8-byte frames of header plus nibbles
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-----------------------------
//  in       | input     | in_valid_i / in_stall_o | in_data_i  (in_byte, first)
//  out      | output    | out_valid_o / out_stall_i | out_data_o (sample, last,
//           |           |                        |   block_done)
//  cfg      | input     | cfg_we_i (no wait)     | cfg_idx_i, cfg_wdata_i
//
// the sample datapath in the back makes one sample per cycle while the output
// is not stalled; a data byte makes up to two sample jobs, a header byte none;
// a byte is taken when the job queue has two free slots
// first sample of a byte passes a job queue slot and then the output register once the byte is taken
// reset clears control state and history; no clearing pass
// out_stall_i holds the output register; while there is room the queue keeps absorbing bytes
// ----------------------------------------------------------------------------
`include "adpcm_frame_decoder_macros.svh"

module adpcm_frame_decoder import adf_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  adf_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output adf_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned LevelW = $clog2(QueueDepth + 1);

  adf_cfg_t          cfg_q;
  logic [15:0]       sample_count_q;
  adf_push_t         push;
  logic              has_room, head_valid, pop;
  adf_op_t           head;
  logic [LevelW-1:0] level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q          <= '0;
      sample_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCoefPairs01: cfg_q.coef[0]  <= cfg_wdata_i;
        RegCoefPairs23: cfg_q.coef[1]  <= cfg_wdata_i;
        RegCoefPairs45: cfg_q.coef[2]  <= cfg_wdata_i;
        RegCoefPairs67: cfg_q.coef[3]  <= cfg_wdata_i;
        RegInitHistory: cfg_q.init_hist <= cfg_wdata_i[31:0];
        RegSampleCount: sample_count_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  adf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_data_i      (in_data_i),
    .has_room_i     (has_room),
    .sample_count_i (sample_count_q),
    .init_hist_i    (cfg_q.init_hist),
    .push_o         (push)
  );

  adf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .pop_i        (pop),
    .has_room_o   (has_room),
    .head_valid_o (head_valid),
    .head_o       (head),
    .level_o      (level)
  );

  adf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  // the block's final sample always closes its byte
  `ADF_ASSERT(a_done_is_last, clk_i, rst_ni, out_valid_o && out_data_o.block_done |-> out_data_o.last)
  // queue level never passes its depth
  `ADF_ASSERT(a_level_bound, clk_i, rst_ni, level <= LevelW'(QueueDepth))
  // an empty queue never holds off the input
  `ADF_ASSERT(a_empty_takes, clk_i, rst_ni, level == '0 |-> !in_stall_o)

endmodule

// ===== hdl/adf_front.sv =====
// ----------------------------------------------------------------------------
// adf_front
// accepts coded bytes, tracks frame position and sample count, and turns
// each data byte into zero, one or two sample jobs
// ----------------------------------------------------------------------------
module adf_front import adf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  adf_in_t     in_data_i,
  input  logic        has_room_i,
  input  logic [15:0] sample_count_i,
  input  logic [31:0] init_hist_i,
  output adf_push_t   push_o
);

  logic        accept;
  logic [3:0]  pos_q, pos_d;
  logic [2:0]  pred_q, pred_d;
  logic [3:0]  shift_q, shift_d;
  logic [15:0] emitted_q, emitted_d;
  logic        reload_q, reload_d;
  logic [31:0] hist_q, hist_d;
  logic [3:0]  pos_eff;
  logic [15:0] emitted_eff;
  logic [15:0] e1, e2;
  logic        avail0, avail1;

  assign accept     = in_valid_i && has_room_i;
  assign in_stall_o = !has_room_i;

  always_comb begin
    pos_d     = pos_q;
    pred_d    = pred_q;
    shift_d   = shift_q;
    emitted_d = emitted_q;
    reload_d  = reload_q;
    hist_d    = hist_q;
    push_o    = '0;

    pos_eff     = in_data_i.first ? HeaderPos : pos_q;
    emitted_eff = in_data_i.first ? 16'd0 : emitted_q;
    e1          = emitted_eff + 16'd1;
    e2          = emitted_eff + 16'd2;
    avail0      = emitted_eff < sample_count_i;
    avail1      = avail0 && (e1 < sample_count_i);

    push_o.op0.reload = reload_q;
    push_o.op0.hist   = hist_q;
    push_o.op0.nibble = in_data_i.in_byte[7:4];
    push_o.op0.pred   = pred_q;
    push_o.op0.shift  = shift_q;
    push_o.op0.last   = !avail1;
    push_o.op0.done   = (e1 == sample_count_i);
    push_o.op1.reload = 1'b0;
    push_o.op1.hist   = hist_q;
    push_o.op1.nibble = in_data_i.in_byte[3:0];
    push_o.op1.pred   = pred_q;
    push_o.op1.shift  = shift_q;
    push_o.op1.last   = 1'b1;
    push_o.op1.done   = (e2 == sample_count_i);

    if (accept) begin
      if (in_data_i.first) begin
        reload_d  = 1'b1;
        emitted_d = 16'd0;
        // starting history is taken at block start, later writes do not reach it
        hist_d    = init_hist_i;
      end
      if (pos_eff == HeaderPos) begin
        pred_d  = in_data_i.in_byte[6:4];
        shift_d = in_data_i.in_byte[3:0];
        pos_d   = PosStep;
      end else begin
        push_o.push0 = avail0;
        push_o.push1 = avail1;
        pos_d        = pos_q + PosStep;
        if (avail1) begin
          emitted_d = e2;
        end else if (avail0) begin
          emitted_d = e1;
        end
        if (avail0) begin
          reload_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      pred_q    <= '0;
      shift_q   <= '0;
      emitted_q <= '0;
      reload_q  <= 1'b0;
      hist_q    <= '0;
    end else begin
      pos_q     <= pos_d;
      pred_q    <= pred_d;
      shift_q   <= shift_d;
      emitted_q <= emitted_d;
      reload_q  <= reload_d;
      hist_q    <= hist_d;
    end
  end

endmodule

// ===== hdl/adf_queue.sv =====
// ----------------------------------------------------------------------------
// adf_queue
// short job queue between front and back: two pushes and one pop per cycle
// ----------------------------------------------------------------------------
module adf_queue import adf_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  adf_push_t                  push_i,
  input  logic                       pop_i,
  output logic                       has_room_o,
  output logic                       head_valid_o,
  output adf_op_t                    head_o,
  output logic [$clog2(Depth+1)-1:0] level_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  adf_op_t          slots_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d, wr_nxt;
  logic [CntW-1:0]  cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_nxt       = ptr_inc(wr_q);
  assign has_room_o   = cnt_q <= CntW'(Depth - 2);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = slots_q[rd_q];
  assign level_o      = cnt_q;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i.push1) begin
      wr_d = ptr_inc(wr_nxt);
    end else if (push_i.push0) begin
      wr_d = wr_nxt;
    end
    if (pop_i) begin
      rd_d = ptr_inc(rd_q);
    end
    cnt_d = cnt_q + CntW'(push_i.push0) + CntW'(push_i.push1) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      slots_q[wr_q] <= push_i.op0;
    end
    if (push_i.push1) begin
      slots_q[wr_nxt] <= push_i.op1;
    end
  end

endmodule

// ===== hdl/adf_back.sv =====
// ----------------------------------------------------------------------------
// adf_back
// sample datapath: prediction, rounding, saturation and history, one sample
// per cycle while the output is not stalled, into a registered output stage
// ----------------------------------------------------------------------------
module adf_back import adf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  adf_cfg_t cfg_i,
  input  logic     head_valid_i,
  input  adf_op_t  head_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output adf_out_t out_data_o
);

  logic signed [15:0] hist1_q, hist2_q;
  logic signed [15:0] h1, h2, c1, c2;
  logic [31:0]        pair;
  logic signed [3:0]  nib_s;
  logic [4:0]         sh_amt;
  logic signed [33:0] term0, acc;
  logic signed [31:0] p1, p2;
  logic signed [22:0] q;
  logic [10:0]        frac;
  logic               rnd;
  logic signed [23:0] qr;
  logic signed [15:0] sample;
  logic               out_valid_q;
  adf_out_t           out_q;

  assign pop_o = head_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    pair   = head_i.pred[0] ? cfg_i.coef[head_i.pred[2:1]][63:32]
                            : cfg_i.coef[head_i.pred[2:1]][31:0];
    c1     = pair[15:0];
    c2     = pair[31:16];
    // block start takes history carried with the job instead of the loop
    h1     = head_i.reload ? head_i.hist[15:0]  : hist1_q;
    h2     = head_i.reload ? head_i.hist[31:16] : hist2_q;
    nib_s  = head_i.nibble;
    sh_amt = {1'b0, head_i.shift} + FracBits;
    term0  = 34'(nib_s) <<< sh_amt;
    p1     = c1 * h1;
    p2     = c2 * h2;
    acc    = term0 + 34'(p1) + 34'(p2);
    q      = acc[33:11];
    frac   = acc[10:0];
    // round half to even
    rnd    = (frac > HalfLsb) || ((frac == HalfLsb) && q[0]);
    qr     = 24'(q) + 24'(rnd);
    if (qr > SatMax) begin
      sample = 16'sh7fff;
    end else if (qr < SatMin) begin
      sample = -16'sh8000;
    end else begin
      sample = qr[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist1_q     <= '0;
      hist2_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        hist1_q     <= sample;
        hist2_q     <= h1;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q.sample     <= sample;
      out_q.last       <= head_i.last;
      out_q.block_done <= head_i.done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the adpcm frame decoder: channel blocks of headers
// and nibble pairs, each accepted byte decoded in a bit-exact software copy,
// samples checked in order under random idling on both sides
// ----------------------------------------------------------------------------
import adf_pkg::*;

class sample_scoreboard;
  logic [CfgDataW-1:0] coef [NumCoefRegs];
  logic [31:0]         init_hist  = '0;
  logic [15:0]         sample_cnt = '0;
  logic [3:0]          frame_pos  = '0;
  logic [2:0]          pred       = '0;
  logic [3:0]          shift      = '0;
  logic signed [15:0]  hist_new   = '0;
  logic signed [15:0]  hist_old   = '0;
  logic [15:0]         emitted    = '0;
  adf_out_t            pending_samples [$];
  int unsigned         mismatches = 0;

  function new();
    foreach (coef[i]) coef[i] = '0;
  endfunction

  function void report(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function int pending();
    return pending_samples.size();
  endfunction

  function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    case (idx)
      RegCoefPairs01, RegCoefPairs23, RegCoefPairs45, RegCoefPairs67: begin
        coef[idx[1:0]] = val;
      end
      RegInitHistory: begin
        init_hist = val[31:0];
      end
      RegSampleCount: begin
        sample_cnt = val[15:0];
      end
      default: ;
    endcase
  endfunction

  // 5.11 prediction plus scaled nibble, round half to even, saturate
  function logic signed [15:0] predict_sample(logic [3:0] nib);
    logic [31:0]        pair;
    logic signed [15:0] c1;
    logic signed [15:0] c2;
    logic signed [3:0]  n;
    longint             acc;
    longint             q;
    longint             frac;
    pair = pred[0] ? coef[pred[2:1]][63:32] : coef[pred[2:1]][31:0];
    c1   = pair[15:0];
    c2   = pair[31:16];
    n    = nib;
    acc  = longint'(n) * (longint'(1) << shift) * 2048
         + longint'(c1) * longint'(hist_new) + longint'(c2) * longint'(hist_old);
    q    = acc >>> 11;
    frac = acc & 2047;
    if (frac > 1024 || (frac == 1024 && q[0])) q++;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    hist_old = hist_new;
    hist_new = q[15:0];
    return q[15:0];
  endfunction

  function void note_byte(adf_in_t d);
    adf_out_t   res [2];
    logic [3:0] nibs [2];
    int         cnt;
    cnt = 0;
    if (d.first) begin
      hist_new  = init_hist[15:0];
      hist_old  = init_hist[31:16];
      emitted   = '0;
      frame_pos = HeaderPos;
    end
    if (frame_pos == HeaderPos) begin
      pred      = d.in_byte[6:4];
      shift     = d.in_byte[3:0];
      frame_pos = PosStep;
      return;
    end
    nibs[0] = d.in_byte[7:4];
    nibs[1] = d.in_byte[3:0];
    for (int k = 0; k < 2; k++) begin
      if (emitted >= sample_cnt) break;
      res[cnt].sample     = predict_sample(nibs[k]);
      emitted             = emitted + 16'd1;
      res[cnt].last       = 1'b0;
      res[cnt].block_done = (emitted == sample_cnt);
      cnt++;
    end
    if (cnt > 0) res[cnt-1].last = 1'b1;
    for (int k = 0; k < cnt; k++) pending_samples.push_back(res[k]);
    frame_pos = frame_pos + PosStep;
  endfunction

  function void check_sample(adf_out_t got);
    adf_out_t want;
    if (pending_samples.size() == 0) begin
      report($sformatf("unexpected sample %0d last %0b done %0b",
                       $signed(got.sample), got.last, got.block_done));
      return;
    end
    want = pending_samples.pop_front();
    if (got.sample !== want.sample || got.last !== want.last ||
        got.block_done !== want.block_done) begin
      report($sformatf({"sample mismatch: expected %0d last %0b done %0b, ",
                        "got %0d last %0b done %0b"},
                       $signed(want.sample), want.last, want.block_done,
                       $signed(got.sample), got.last, got.block_done));
    end
  endfunction
endclass

module tb;

  logic                clk;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  adf_in_t             in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  adf_out_t            out_data_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  int   sender_idle_pct;
  int   recv_stall_pct;
  logic hold_off;

  sample_scoreboard sb = new();

  // header, nibble extremes, restart mid frame, block end inside a byte
  logic [8:0] directed_bytes [0:20] = '{
    9'h08F, 9'h087, 9'h078, 9'h0FF, 9'h000, 9'h011,
    9'h170, 9'h01E, 9'h0E1,
    9'h135, 9'h07F, 9'h080, 9'h0F7, 9'h08F, 9'h055, 9'h0AA, 9'h0C3,
    9'h02C, 9'h09A, 9'h0B4, 9'h0D2
  };

  adpcm_frame_decoder u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_sample(out_data_o);
      if (in_valid_i && !in_stall_o) sb.note_byte(in_data_i);
    end
  end

  task automatic send_byte(adf_in_t d);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic program_block(logic [CfgDataW-1:0] c01, logic [CfgDataW-1:0] c23,
                               logic [CfgDataW-1:0] c45, logic [CfgDataW-1:0] c67,
                               logic [31:0] hist, logic [15:0] count);
    write_reg(RegCoefPairs01, c01);
    write_reg(RegCoefPairs23, c23);
    write_reg(RegCoefPairs45, c45);
    write_reg(RegCoefPairs67, c67);
    write_reg(RegInitHistory, {32'd0, hist});
    write_reg(RegSampleCount, {48'd0, count});
    cfg_we_i <= 1'b0;
  endtask

  // waits until no sample is pending, then idles before the next register writes
  task automatic wait_drained();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin sender_idle_pct = 0;  recv_stall_pct <= 0;  end
      1: begin sender_idle_pct = 60; recv_stall_pct <= 0;  end
      2: begin sender_idle_pct = 0;  recv_stall_pct <= 60; end
      default: begin sender_idle_pct = 13; recv_stall_pct <= 13; end
    endcase
  endtask

  // coefficients that keep the history mostly in range
  function automatic logic [31:0] tame_pair();
    logic [15:0] c1;
    logic [15:0] c2;
    c1 = 16'($urandom_range(0, 4096));
    c2 = -16'($urandom_range(0, 2048));
    return {c2, c1};
  endfunction

  function automatic logic [CfgDataW-1:0] pick_coef(int mode);
    case (mode)
      0: return {tame_pair(), tame_pair()};
      1: return {$urandom, $urandom};
      default: begin
        case ($urandom_range(3))
          0: return 64'h8000_7fff_7fff_8000;
          1: return '1;
          2: return '0;
          default: return 64'h0000_8000_8000_0000;
        endcase
      end
    endcase
  endfunction

  // mostly well-formed blocks, some without a leading first, rare restarts
  task automatic run_blocks(int n_items);
    adf_in_t d;
    int      sent;
    int      len;
    int      pos;
    logic    lead_first;
    sent = 0;
    pos  = 0;
    while (sent < n_items) begin
      len        = ($urandom_range(9) == 0) ? $urandom_range(41, 80) : $urandom_range(1, 40);
      lead_first = ($urandom_range(7) != 0);
      for (int j = 0; j < len; j++) begin
        d.first = (j == 0) ? lead_first : ($urandom_range(99) == 0);
        if (d.first) pos = 0;
        if (pos == 0) begin
          d.in_byte[7]   = 1'($urandom_range(1));
          d.in_byte[6:4] = 3'($urandom_range(7));
          d.in_byte[3:0] = 4'(($urandom_range(3) == 0) ? $urandom_range(15)
                                                        : $urandom_range(10));
        end else begin
          d.in_byte = 8'($urandom_range(255));
        end
        pos = (pos + 1) % 8;
        send_byte(d);
        sent++;
      end
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    adf_in_t     d;
    logic [15:0] count;
    logic [31:0] hist;
    int          cmode;
    in_valid_i      <= 1'b0;
    in_data_i       <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= RegCoefPairs01;
    cfg_wdata_i     <= '0;
    hold_off        <= 1'b0;
    recv_stall_pct  <= 0;
    sender_idle_pct = 0;
    rst_ni          = 1'b0;
    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // directed: no leading first, saturation, restart, block end mid byte
    program_block(64'h0000_0000_8000_7fff, 64'h0800_1000_f800_0800,
                  64'hffff_ffff_0000_0000, 64'h8000_8000_7fff_7fff,
                  32'h8000_7fff, 16'd13);
    set_idling(3);
    foreach (directed_bytes[i]) begin
      d.first   = directed_bytes[i][8];
      d.in_byte = directed_bytes[i][7:0];
      send_byte(d);
    end
    in_valid_i <= 1'b0;
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: count = 16'hffff;
        1: count = 16'd0;
        2: count = 16'd1;
        3: count = 16'($urandom_range(1, 300));
        default: count = 16'($urandom_range(1, 60));
      endcase
      case ($urandom_range(3))
        0: hist = $urandom;
        1: hist = '1;
        2: hist = 32'h7fff_8000;
        default: hist = '0;
      endcase
      cmode = ph % 3;
      program_block(pick_coef(cmode), pick_coef(cmode), pick_coef(cmode), pick_coef(cmode),
                    hist, count);
      set_idling(ph % 4);
      if (ph == 0) begin
        // long receiver hold-off while bytes keep coming, fills the job queue
        fork
          begin
            hold_off <= 1'b1;
            repeat (300) @(posedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end
      run_blocks(205);
      wait_drained();
    end

    while (sb.pending() != 0) begin
      void'(sb.pending_samples.pop_front());
      sb.report("expected sample never arrived");
    end
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== adpcm_frame_decoder.f =====
+incdir+hdl
hdl/adf_pkg.sv
hdl/adf_front.sv
hdl/adf_queue.sv
hdl/adf_back.sv
hdl/adpcm_frame_decoder.sv
sim/tb.sv
